// ----- rtl/core/sapq_pkg.sv -----
// Shared widths, codes and types of the sorted array priority queue.
package sapq_pkg;

    localparam int DATA_W          = 32;
    localparam int PRIO_W          = 32;
    localparam int STATUS_W        = 2;
    localparam int HELD_W          = 8;
    localparam int QUEUE_DEPTH_DEF = 128;

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } t_slot;

    // Command broadcast to every cell
    typedef struct packed {
        logic  insert;
        logic  remove;
        t_slot entry;
    } t_cell_cmd;

endpackage

// ----- rtl/core/sapq_if.sv -----
// Request and response channel interfaces of the priority queue.
interface sapq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [sapq_pkg::DATA_W-1:0]  item_data;
    logic signed [sapq_pkg::PRIO_W-1:0]  item_priority;

    modport source (output valid, output req_type, output item_data,
                    output item_priority, input ready);
    modport sink   (input valid, input req_type, input item_data,
                    input item_priority, output ready);
endinterface

interface sapq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sapq_pkg::STATUS_W-1:0]       status;
    logic signed [sapq_pkg::DATA_W-1:0]  removed_data;
    logic signed [sapq_pkg::PRIO_W-1:0]  removed_priority;
    logic [sapq_pkg::HELD_W-1:0]         entries_held;

    modport source (output valid, output status, output removed_data,
                    output removed_priority, output entries_held, input ready);
    modport sink   (input valid, input status, input removed_data,
                    input removed_priority, input entries_held, output ready);
endinterface

// ----- rtl/core/sorted_array_priority_queue_unit.sv -----
// Top level of the sorted array priority queue: cell row, count and response register.
// A request is taken in every cycle in which the response register is empty or being
// drained, and its response is registered there, so while responses drain the queue
// sustains one insert or remove per clock. The entries live in a row of QUEUE_DEPTH
// cells kept sorted from highest priority (slot 0) downward; the insert priority is
// broadcast to all cells, each compares against its own entry, and the whole row shifts
// back or forward in that same clock. Equal priorities leave in arrival order. A full
// insert returns status 1, an empty remove status 2; removed fields are zero unless a
// remove succeeds. entries_held is the count after the request, modulo 256.
module sorted_array_priority_queue_unit #(
    parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sapq_req_if.sink  i_req,
    sapq_rsp_if.source o_rsp
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  n_occ;
    logic              r_valid;
    logic [sapq_pkg::STATUS_W-1:0] r_status;
    logic [sapq_pkg::STATUS_W-1:0] n_status;
    sapq_pkg::t_slot   r_removed;
    sapq_pkg::t_slot   n_removed;
    logic [sapq_pkg::HELD_W-1:0] r_held;

    logic              accept;
    logic              full;
    logic              empty;
    sapq_pkg::t_cell_cmd cmd;

    sapq_pkg::t_slot   slot  [QUEUE_DEPTH];
    logic              take  [QUEUE_DEPTH];

    // Accept a beat while the response register is free or draining
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign empty       = (r_occ == '0);

    // Broadcast the command to the row
    always_comb begin
        cmd.insert     = accept && (i_req.req_type == sapq_pkg::REQ_INSERT) && !full;
        cmd.remove     = accept && (i_req.req_type == sapq_pkg::REQ_REMOVE) && !empty;
        cmd.entry.data = i_req.item_data;
        cmd.entry.prio = i_req.item_priority;
    end

    // Build the cell row
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        sapq_pkg::t_slot left_slot;
        sapq_pkg::t_slot right_slot;
        logic            left_take;

        if (g == 0) begin : g_head
            assign left_slot = '0;
            assign left_take = 1'b0;
        end else begin : g_body
            assign left_slot = slot[g-1];
            assign left_take = take[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_slot = '0;
        end else begin : g_inner
            assign right_slot = slot[g+1];
        end

        sapq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_left      (left_slot),
            .i_left_take (left_take),
            .i_right     (right_slot),
            .i_occupied  (OCC_W'(g) < r_occ),
            .o_slot      (slot[g]),
            .o_take      (take[g])
        );
    end

    // Form the response and the next count
    always_comb begin
        n_occ     = r_occ;
        n_status  = sapq_pkg::ST_DONE;
        n_removed = '0;
        if (i_req.req_type == sapq_pkg::REQ_INSERT) begin
            if (full) begin
                n_status = sapq_pkg::ST_FULL;
            end else begin
                n_occ = r_occ + OCC_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = sapq_pkg::ST_EMPTY;
            end else begin
                n_occ     = r_occ - OCC_W'(1);
                n_removed = slot[0];
            end
        end
    end

    // Track count and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_occ   <= n_occ;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_held    <= sapq_pkg::HELD_W'(n_occ);
        end
    end

    assign o_rsp.valid            = r_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.removed_data     = r_removed.data;
    assign o_rsp.removed_priority = r_removed.prio;
    assign o_rsp.entries_held     = r_held;

endmodule

// ----- rtl/core/sapq_cell.sv -----
// One slot of the sorted shifting store.
module sapq_cell (
    input  logic                i_clk,
    input  sapq_pkg::t_cell_cmd i_cmd,
    input  sapq_pkg::t_slot     i_left,
    input  logic                i_left_take,
    input  sapq_pkg::t_slot     i_right,
    input  logic                i_occupied,
    output sapq_pkg::t_slot     o_slot,
    output logic                o_take
);

    sapq_pkg::t_slot r_slot;
    sapq_pkg::t_slot n_slot;

    // Flag this slot as displaced by the new entry: empty or strictly lower priority
    assign o_take = !i_occupied || ($signed(r_slot.prio) < $signed(i_cmd.entry.prio));
    assign o_slot = r_slot;

    // Pick next content: hold, take new entry, shift back, or advance forward
    always_comb begin
        n_slot = r_slot;
        if (i_cmd.insert && o_take) begin
            n_slot = i_left_take ? i_left : i_cmd.entry;
        end else if (i_cmd.remove) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench of the sorted array priority queue: directed table, random phases, queue predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sapq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 25;

    localparam logic signed [31:0] MAX_S32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_S32 = 32'sh8000_0000;

    // One response beat as the queue reports it
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] rdata;
        logic signed [PRIO_W-1:0] rprio;
        logic [HELD_W-1:0]        held;
    } t_outcome;

    // One row of the directed table; the outcome is used only when chk is set
    typedef struct packed {
        logic                     chk;
        logic                     kind;
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
        t_outcome                 outcome;
    } t_row;

    localparam t_outcome NO_CHECK = '0;

    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // remove on empty queue, payload ignored
        '{1'b1, REQ_REMOVE, MAX_S32, MAX_S32, '{ST_EMPTY, 32'sd0, 32'sd0, 8'd0}},
        // extremes of data and priority
        '{1'b1, REQ_INSERT, MAX_S32, MAX_S32, '{ST_DONE, 32'sd0, 32'sd0, 8'd1}},
        '{1'b1, REQ_INSERT, MIN_S32, MIN_S32, '{ST_DONE, 32'sd0, 32'sd0, 8'd2}},
        '{1'b1, REQ_INSERT, 32'sd0, 32'sd0, '{ST_DONE, 32'sd0, 32'sd0, 8'd3}},
        '{1'b1, REQ_INSERT, -32'sd1, -32'sd1, '{ST_DONE, 32'sd0, 32'sd0, 8'd4}},
        // equal priorities leave in arrival order
        '{1'b0, REQ_INSERT, 32'sd11, 32'sd5, NO_CHECK},
        '{1'b0, REQ_INSERT, 32'sd12, 32'sd5, NO_CHECK},
        '{1'b0, REQ_INSERT, 32'sd13, 32'sd5, NO_CHECK},
        '{1'b1, REQ_REMOVE, -32'sd1, -32'sd1, '{ST_DONE, MAX_S32, MAX_S32, 8'd6}},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        // tie at the lowest priority, then a new front entry
        '{1'b0, REQ_INSERT, 32'sd14, MIN_S32, NO_CHECK},
        '{1'b0, REQ_INSERT, 32'sd15, MAX_S32, NO_CHECK},
        '{1'b0, REQ_REMOVE, MIN_S32, MAX_S32, NO_CHECK},
        // drain to empty
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b1, REQ_REMOVE, 32'sd0, 32'sd0, '{ST_EMPTY, 32'sd0, 32'sd0, 8'd0}},
        // alternating bit patterns
        '{1'b0, REQ_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA, NO_CHECK},
        '{1'b0, REQ_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555, NO_CHECK},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b0, REQ_REMOVE, 32'sd0, 32'sd0, NO_CHECK},
        '{1'b1, REQ_REMOVE, 32'sd0, 32'sd0, '{ST_EMPTY, 32'sd0, 32'sd0, 8'd0}}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sapq_req_if req_ch ();
    sapq_rsp_if rsp_ch ();

    sorted_array_priority_queue_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow of the sorted store, front entry first
    t_slot    queue_shadow[$];
    t_outcome awaited_outcomes[$];
    int       fail_count  = 0;
    int unsigned cycle_count = 0;
    bit       src_calm = 1'b0;
    bit       snk_calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one request to the shadow store and return its outcome
    function automatic t_outcome apply_request(logic kind, logic signed [DATA_W-1:0] data,
                                               logic signed [PRIO_W-1:0] prio);
        t_outcome res;
        t_slot    entry;
        int       pos;
        res = '0;
        if (kind == REQ_INSERT) begin
            if (queue_shadow.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // go behind every entry of greater or equal priority
                pos = queue_shadow.size();
                while (pos > 0 && queue_shadow[pos-1].prio < prio) pos--;
                entry.data = data;
                entry.prio = prio;
                queue_shadow.insert(pos, entry);
            end
        end else if (queue_shadow.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            entry = queue_shadow.pop_front();
            res.rdata = entry.data;
            res.rprio = entry.prio;
        end
        res.held = HELD_W'(queue_shadow.size());
        return res;
    endfunction

    // Narrow ranges often, so ties are common, plus extremes and full-width values
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return PRIO_W'($urandom_range(0, 7)) - 3;
            4: return MAX_S32;
            5: return MIN_S32;
            default: return $urandom;
        endcase
    endfunction

    // Drive one request beat, hold it until taken, then record its outcome
    task automatic send_request(logic kind, logic signed [DATA_W-1:0] data,
                                logic signed [PRIO_W-1:0] prio, logic chk, t_outcome typed);
        int       gap;
        t_outcome model_res;
        gap = src_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.item_data     <= data;
        req_ch.item_priority <= prio;
        do @(posedge i_clk); while (!req_ch.ready);
        model_res = apply_request(kind, data, prio);
        awaited_outcomes.push_back(chk ? typed : model_res);
    endtask

    task automatic send_random(int insert_pct);
        logic kind;
        kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        send_request(kind, $urandom, pick_priority(), 1'b0, NO_CHECK);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare every response beat with the oldest outcome waiting
    always @(posedge i_clk) begin : rsp_monitor
        t_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_outcomes.size() == 0) begin
                $error("response beat with no request outstanding");
                fail_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_ch.status));
                check_field("removed_data", want.rdata, rsp_ch.removed_data);
                check_field("removed_priority", want.rprio, rsp_ch.removed_priority);
                check_field("entries_held", 32'(want.held), 32'(rsp_ch.entries_held));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Randomly stall the response side before each beat
    initial begin : rsp_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = snk_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    initial begin : stimulus
        t_row row;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_INSERT;
        req_ch.item_data     <= '0;
        req_ch.item_priority <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            send_request(row.kind, row.data, row.prio, row.chk, row.outcome);
        end

        // Fill past full back to back, so refused inserts show up
        src_calm = 1'b1;
        snk_calm = 1'b1;
        repeat (140) send_random(100);

        // Drain past empty with idles on both sides
        src_calm = 1'b0;
        snk_calm = 1'b0;
        repeat (145) send_random(5);

        // Mixed traffic in chunks of varying balance and idling
        repeat (8) begin
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            repeat (55) send_random($urandom_range(25, 75));
        end

        // Let the last responses come home
        req_ch.valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
